// ===== sv/kcl_pkg.sv =====
// Shared types and constants for the keypad code lock.
package kcl_pkg;

  // Default number of characters in an access code
  localparam int CODE_DIGITS_DEF = 4;

  // Special keys
  localparam logic [7:0] KEY_HASH = 8'h23;
  localparam logic [7:0] KEY_STAR = 8'h2A;
  localparam logic [7:0] KEY_NONE = 8'h00;

  // Input operation codes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Result codes
  typedef enum logic [1:0] {
    OUT_NONE    = 2'd0,
    OUT_UNLOCK  = 2'd1,
    OUT_WRONG   = 2'd2,
    OUT_CHANGED = 2'd3
  } outcome_t;

  // Per-transaction control broadcast to every cell
  typedef struct packed {
    logic step;   // a key is being appended this cycle
    logic clear;  // the buffer empties after this key
  } cell_ctl_t;

  // Running compare results passed along the chain
  typedef struct packed {
    logic open_ok;    // buffer start matches the stored code
    logic change_ok;  // buffer after the leading '#' matches the stored code
  } match_t;

endpackage

// ===== sv/kcl_key_cell.sv =====
// One key slot of the buffer chain: holds a key, passes the write token and compare results.
module kcl_key_cell
  import kcl_pkg::*;
#(
  parameter bit FIRST      = 1'b0,
  parameter bit USE_OPEN   = 1'b0,
  parameter bit USE_CHANGE = 1'b0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  input  logic [7:0] key,
  input  logic       tok_in,
  output logic       tok_out,
  input  logic [7:0] exp_open,
  input  logic [7:0] exp_change,
  input  match_t     match_in,
  output match_t     match_out,
  output logic [7:0] key_eff
);

  logic [7:0] key_r;
  logic       tok_r;
  logic       tok_nxt;

  // Store the key when this slot holds the write token
  always_ff @(posedge clk) begin
    if (ctl.step && tok_r) begin
      key_r <= key;
    end
  end

  // Advance the write token on each key, return it to the head on clear
  always_comb begin
    tok_nxt = tok_r;
    if (ctl.step) begin
      tok_nxt = ctl.clear ? FIRST : tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= FIRST;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

  // Slot contents as seen after the incoming key lands
  assign key_eff = tok_r ? key : key_r;

  // Extend the compare results along the chain
  assign match_out.open_ok   = match_in.open_ok &
                               (!USE_OPEN || (key_eff == exp_open));
  assign match_out.change_ok = match_in.change_ok &
                               (!USE_CHANGE || (key_eff == exp_change));

endmodule

// ===== sv/keypad_code_lock_unit.sv =====
// Keypad code lock: key buffer chain, stored code and result register.
//
// Input channel (in_valid/in_ready): one transaction is either a key press
// (in_op = 0, ASCII in in_key_char, zero means no key) or a load of the
// stored code (in_op = 1, in_load_value, first character in the low byte).
// Result channel (out_valid/out_ready): exactly one result per input
// transaction: outcome, the stored code after the step for write-back, and
// the number of keys buffered.
// The result is valid in the cycle after the input is accepted. Throughput is
// one transaction per cycle while results are taken; the key store, token
// advance and the chained byte compare all settle within the accepting cycle.
// The result register decouples the sides: a new transaction is taken in the
// same cycle the pending result is taken. While the receiver stalls, the
// result holds and no input is accepted.
// Reset empties the key buffer, clears the stored code to zero (matches no
// printable code) and drops any pending result.
module keypad_code_lock_unit
  import kcl_pkg::*;
#(
  parameter int CODE_DIGITS = CODE_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_key_char,
  input  logic [31:0] in_load_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_outcome,
  output logic [31:0] out_code_out,
  output logic [3:0]  out_keys_held
);

  localparam int CHANGE_LEN = 2 * CODE_DIGITS + 2;
  localparam int CNT_W      = $clog2(CHANGE_LEN + 1);
  localparam int IDX_W      = $clog2(CHANGE_LEN);
  localparam int CODE_BYTES = (CODE_DIGITS > 4) ? CODE_DIGITS : 4;
  localparam int CODE_W     = 8 * CODE_BYTES;

  logic                  in_acc;
  logic                  key_step;
  cell_ctl_t             ctl;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic [CNT_W-1:0]      cnt_inc;
  logic [CODE_W-1:0]     code_r;
  logic [CODE_W-1:0]     code_nxt;
  logic [CODE_W-1:0]     code_swap;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  outcome_t              outcome_r;
  outcome_t              outcome_nxt;
  logic                  chk_open;
  logic                  chk_change;
  logic                  change_form;
  logic [CHANGE_LEN-1:0] tok_v;
  logic [7:0]            eff_v   [CHANGE_LEN];
  logic [7:0]            exp_o_v [CHANGE_LEN];
  logic [7:0]            exp_c_v [CHANGE_LEN];
  match_t                match_v [CHANGE_LEN+1];
  logic [CNT_W+3:0]      cnt_ext;

  // Handshake
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign key_step = in_acc && (in_op == OP_KEY) && (in_key_char != KEY_NONE);

  // Decide what the buffer looks like after this key
  assign cnt_inc     = cnt_r + CNT_W'(1);
  assign chk_open    = (cnt_inc == CNT_W'(CODE_DIGITS)) && (eff_v[0] != KEY_HASH);
  assign chk_change  = (cnt_inc == CNT_W'(CHANGE_LEN));
  assign change_form = (eff_v[0] == KEY_HASH) && (eff_v[CODE_DIGITS+1] == KEY_STAR);

  assign ctl.step  = key_step;
  assign ctl.clear = chk_open || chk_change;

  assign match_v[0].open_ok   = 1'b1;
  assign match_v[0].change_ok = 1'b1;

  // Build the chain of key slots
  for (genvar i = 0; i < CHANGE_LEN; i++) begin : g_cell
    if (i < CODE_DIGITS) begin : g_exp_o
      assign exp_o_v[i] = code_r[8*i +: 8];
    end else begin : g_no_exp_o
      assign exp_o_v[i] = 8'h00;
    end
    if ((i >= 1) && (i <= CODE_DIGITS)) begin : g_exp_c
      assign exp_c_v[i] = code_r[8*(i-1) +: 8];
    end else begin : g_no_exp_c
      assign exp_c_v[i] = 8'h00;
    end

    logic tok_left;
    if (i == 0) begin : g_head
      assign tok_left = 1'b0;
    end else begin : g_body
      assign tok_left = tok_v[i-1];
    end

    kcl_key_cell #(
      .FIRST      (i == 0),
      .USE_OPEN   (i < CODE_DIGITS),
      .USE_CHANGE ((i >= 1) && (i <= CODE_DIGITS))
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .key        (in_key_char),
      .tok_in     (tok_left),
      .tok_out    (tok_v[i]),
      .exp_open   (exp_o_v[i]),
      .exp_change (exp_c_v[i]),
      .match_in   (match_v[i]),
      .match_out  (match_v[i+1]),
      .key_eff    (eff_v[i])
    );
  end

  // Gather the new code from the tail of the change sequence
  for (genvar b = 0; b < CODE_BYTES; b++) begin : g_code_swap
    if (b < CODE_DIGITS) begin : g_take
      assign code_swap[8*b +: 8] = eff_v[CODE_DIGITS+2+b];
    end else begin : g_zero
      assign code_swap[8*b +: 8] = 8'h00;
    end
  end

  // Next count, stored code and outcome
  always_comb begin
    cnt_nxt     = cnt_r;
    code_nxt    = code_r;
    outcome_nxt = OUT_NONE;
    if (in_acc && (in_op == OP_LOAD)) begin
      code_nxt = CODE_W'(in_load_value);
    end else if (key_step) begin
      cnt_nxt = cnt_inc;
      if (chk_open) begin
        outcome_nxt = match_v[CHANGE_LEN].open_ok ? OUT_UNLOCK : OUT_WRONG;
        cnt_nxt     = '0;
      end else if (chk_change) begin
        if (change_form) begin
          if (match_v[CHANGE_LEN].change_ok) begin
            code_nxt    = code_swap;
            outcome_nxt = OUT_CHANGED;
          end else begin
            outcome_nxt = OUT_WRONG;
          end
        end
        cnt_nxt = '0;
      end
    end
  end

  // Hold a result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      code_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      outcome_r <= outcome_nxt;
    end
  end

  // Count and code only change on acceptance, so they track the held result
  assign cnt_ext       = {4'b0000, cnt_r};
  assign out_valid     = out_valid_r;
  assign out_outcome   = outcome_r;
  assign out_code_out  = code_r[31:0];
  assign out_keys_held = cnt_ext[3:0];

  // Exactly one slot holds the write token
  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(tok_v))
    else $error("write token not one-hot");

  // The token sits at the slot the count points to
  a_tok_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r < CNT_W'(CHANGE_LEN)) && tok_v[cnt_r[IDX_W-1:0]])
    else $error("write token out of step with key count");

  // A decided sequence always leaves the buffer empty
  a_clear_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (outcome_r != OUT_NONE) |-> (cnt_r == '0))
    else $error("keys left after a decision");

  // A load shows up in the stored code on the next result
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_op == OP_LOAD) |=> (out_code_out == $past(in_load_value)))
    else $error("stored code not loaded");

endmodule

// ===== tb/keypad_code_lock_unit_test.sv =====
// Self-checking testbench for the keypad code lock: directed sequences, random traffic, backpressure.
module keypad_code_lock_unit_test;
  import kcl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGITS       = CODE_DIGITS_DEF;
  localparam int CHANGE_LEN   = 2 * DIGITS + 2;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 215;

  typedef struct packed {
    outcome_t    outcome;
    logic [31:0] code;
    logic [3:0]  keys;
  } lock_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [7:0]  in_key_char;
  logic [31:0] in_load_value;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_outcome;
  logic [31:0] out_code_out;
  logic [3:0]  out_keys_held;

  // Predictor state: keys typed so far and the access code in force
  logic [7:0]  typed_keys [CHANGE_LEN];
  int unsigned typed_count;
  logic [31:0] lock_code;

  lock_result_t predicted_results [$];

  int tx_idle_pct;
  int rx_stall_pct;
  int hold_off_left;
  int items_sent;
  int mismatches;
  int cycle_count;
  int n_unlock;
  int n_wrong;
  int n_changed;
  int n_quiet;

  keypad_code_lock_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_key_char  (in_key_char),
    .in_load_value(in_load_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_outcome  (out_outcome),
    .out_code_out (out_code_out),
    .out_keys_held(out_keys_held)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Empty the typed-key buffer
  function automatic void clear_typed();
    for (int i = 0; i < CHANGE_LEN; i++) typed_keys[i] = KEY_NONE;
    typed_count = 0;
  endfunction

  // Compare DIGITS typed keys from position start with the access code
  function automatic bit typed_matches(input int start);
    for (int i = 0; i < DIGITS; i++) begin
      if (typed_keys[start + i] != lock_code[8 * i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the lock state by one transaction and return the result it causes
  function automatic lock_result_t predict_lock(input logic op, input logic [7:0] key,
                                                input logic [31:0] load);
    lock_result_t r;
    r.outcome = OUT_NONE;
    if (op == OP_LOAD) begin
      lock_code = load;
    end else if (key != KEY_NONE) begin
      if (typed_count < CHANGE_LEN) begin
        typed_keys[typed_count] = key;
        typed_count++;
      end
      if (typed_count == DIGITS && typed_keys[0] != KEY_HASH) begin
        r.outcome = typed_matches(0) ? OUT_UNLOCK : OUT_WRONG;
        clear_typed();
      end else if (typed_count >= CHANGE_LEN) begin
        // a full buffer without the star in place is dropped quietly
        if (typed_keys[0] == KEY_HASH && typed_keys[DIGITS + 1] == KEY_STAR) begin
          if (typed_matches(1)) begin
            for (int i = 0; i < DIGITS; i++) lock_code[8 * i +: 8] = typed_keys[DIGITS + 2 + i];
            r.outcome = OUT_CHANGED;
          end else begin
            r.outcome = OUT_WRONG;
          end
        end
        clear_typed();
      end
    end
    r.code = lock_code;
    r.keys = 4'(typed_count);
    return r;
  endfunction

  // Keys are mostly digits, sometimes any nonzero byte
  function automatic logic [7:0] pick_key();
    if ($urandom_range(99) < 70) return 8'h30 + 8'($urandom_range(9));
    return 8'($urandom_range(1, 255));
  endfunction

  // Record a prediction for each accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      predicted_results.push_back(predict_lock(in_op, in_key_char, in_load_value));
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    lock_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result: outcome %0d code %h keys %0d", $time,
                 out_outcome, out_code_out, out_keys_held);
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        if (out_outcome !== want.outcome) begin
          $display("%0t: outcome mismatch: expected %0d, actual %0d", $time,
                   want.outcome, out_outcome);
          mismatches++;
        end
        if (out_code_out !== want.code) begin
          $display("%0t: code_out mismatch: expected %h, actual %h", $time,
                   want.code, out_code_out);
          mismatches++;
        end
        if (out_keys_held !== want.keys) begin
          $display("%0t: keys_held mismatch: expected %0d, actual %0d", $time,
                   want.keys, out_keys_held);
          mismatches++;
        end
        case (want.outcome)
          OUT_UNLOCK:  n_unlock++;
          OUT_WRONG:   n_wrong++;
          OUT_CHANGED: n_changed++;
          default:     n_quiet++;
        endcase
      end
    end
  end

  // Receiver: honor a long hold-off first, otherwise stall at random
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ready = 1'b0;
      hold_off_left--;
    end else begin
      out_ready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, predicted_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one transaction; called at a falling edge, returns at a falling edge after acceptance
  task automatic send_txn(input logic op, input logic [7:0] key, input logic [31:0] load);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_op         = op;
    in_key_char   = key;
    in_load_value = load;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!(op == OP_KEY && key == KEY_NONE)) items_sent++;
    @(negedge clk);
  endtask

  // Key press with junk in the unused load field
  task automatic send_key(input logic [7:0] key);
    send_txn(OP_KEY, key, $urandom);
  endtask

  // Code load with junk in the unused key field
  task automatic send_load(input logic [31:0] code);
    send_txn(OP_LOAD, 8'($urandom_range(255)), code);
  endtask

  // Occasionally slip a no-key press or a load into a sequence
  task automatic maybe_noise();
    if ($urandom_range(99) < 5) begin
      if ($urandom_range(1)) send_key(KEY_NONE);
      else send_load($urandom);
    end
  endtask

  // Byte i of the stored code as a typeable key, or a random key where it is zero
  function automatic logic [7:0] code_key(input int i);
    if (lock_code[8 * i +: 8] == KEY_NONE) return pick_key();
    return lock_code[8 * i +: 8];
  endfunction

  // Four-key open attempt, right or wrong
  task automatic send_open_attempt();
    bit right;
    logic [7:0] k;
    right = ($urandom_range(99) < 50);
    for (int i = 0; i < DIGITS; i++) begin
      k = right ? code_key(i) : pick_key();
      if (i == 0 && k == KEY_HASH) k = 8'h30;
      maybe_noise();
      send_key(k);
    end
  endtask

  // '#', old code, '*', new code; sometimes a wrong old code or a missing star
  task automatic send_change_attempt();
    bit right;
    bit has_star;
    logic [7:0] k;
    right    = ($urandom_range(99) < 70);
    has_star = ($urandom_range(99) < 85);
    send_key(KEY_HASH);
    for (int i = 0; i < DIGITS; i++) begin
      maybe_noise();
      send_key(right ? code_key(i) : pick_key());
    end
    k = pick_key();
    if (k == KEY_STAR) k = 8'h2B;
    send_key(has_star ? KEY_STAR : k);
    for (int i = 0; i < DIGITS; i++) begin
      maybe_noise();
      send_key(pick_key());
    end
  endtask

  // Random load: half the time every byte is typeable
  task automatic send_random_load();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(1)) begin
      for (int i = 0; i < 4; i++) v[8 * i +: 8] = pick_key();
    end
    send_load(v);
  endtask

  // All-ones code opened with four 0xFF keys
  task automatic test_extreme_code_unlock();
    send_load(32'hFFFF_FFFF);
    for (int i = 0; i < DIGITS; i++) send_key(8'hFF);
  endtask

  // Wrong code with a no-key press in the middle
  task automatic test_wrong_with_no_key();
    send_load(32'h3433_3231);  // "1234"
    send_key("1");
    send_key("2");
    send_key(KEY_NONE);
    send_key("3");
    send_key("5");
  endtask

  // Change "1234" to "9876", then open with the new code
  task automatic test_change_code();
    send_key(KEY_HASH);
    send_key("1");
    send_key("2");
    send_key("3");
    send_key("4");
    send_key(KEY_STAR);
    send_key("9");
    send_key("8");
    send_key("7");
    send_key("6");
    send_key("9");
    send_key("8");
    send_key("7");
    send_key("6");
  endtask

  // Random mix of sequences under one idling setting
  task automatic test_random_phase(input int tx_pct, input int rx_pct, input int n_items);
    int stop_at;
    int pick;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    stop_at      = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40) send_open_attempt();
      else if (pick < 75) send_change_attempt();
      else if (pick < 85) send_random_load();
      else if (pick < 92) send_key(KEY_NONE);
      else send_key(8'($urandom_range(255)));
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    @(posedge clk);
    hold_off_left = 150;
    @(negedge clk);
    send_open_attempt();
    send_change_attempt();
    send_open_attempt();
    send_open_attempt();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_KEY;
    in_key_char   = KEY_NONE;
    in_load_value = '0;
    out_ready     = 1'b0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    hold_off_left = 0;
    items_sent    = 0;
    mismatches    = 0;
    cycle_count   = 0;
    n_unlock      = 0;
    n_wrong       = 0;
    n_changed     = 0;
    n_quiet       = 0;
    lock_code     = '0;
    clear_typed();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_extreme_code_unlock();
    test_wrong_with_no_key();
    test_change_code();
    test_random_phase(0, 0, PHASE_ITEMS);
    test_random_phase(68, 0, PHASE_ITEMS);
    test_random_phase(0, 68, PHASE_ITEMS);
    test_random_phase(20, 20, PHASE_ITEMS);
    test_backpressure();

    // Drain, then keep watching for stray results
    in_valid = 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d key and load transactions over four idling mixes plus a long stall.",
             items_sent);
    $display("Results: %0d unlocked, %0d wrong, %0d code changes, %0d with no outcome.",
             n_unlock, n_wrong, n_changed, n_quiet);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
